// File: rtl/cchb_pkg.sv
package cchb_pkg;

	localparam int unsigned IdW = 29;
	localparam int unsigned DataW = 64;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 32;
	localparam int unsigned SecW = 23;
	localparam int unsigned RemW = 10;

	localparam logic [CfgIdxW-1:0] REG_NODE_ID = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_BEAT_PERIOD = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_CMD_BASE = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_ACK_BASE = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_BEAT_BASE = 3'd4;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_FRAME = 1'b1;

	localparam logic [7:0] CMD_PING = 8'h01;
	localparam logic [7:0] CMD_BEAT = 8'h02;
	localparam logic [7:0] CODE_UNKNOWN = 8'h7F;
	localparam logic [7:0] ACK_TAG0 = 8'h43;
	localparam logic [7:0] ACK_TAG1 = 8'h53;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_BAD_ARG = 2'd1;
	localparam logic [1:0] STATUS_SAMPLE_ERR = 2'd2;

	localparam logic [31:0] BEAT_PERIOD_RST = 32'd1000;
	localparam logic [RemW-1:0] MS_PER_SEC_LAST = 10'd999;

	// reciprocal multipliers: x/10 for 20 bits, x/100 for 23 bits, x/10 for 16 bits
	localparam logic [19:0] RECIP10_V = 20'd838861;
	localparam int unsigned SHIFT10_V = 23;
	localparam logic [23:0] RECIP100 = 24'd10737419;
	localparam int unsigned SHIFT100 = 30;
	localparam logic [16:0] RECIP10_T = 17'd104858;
	localparam int unsigned SHIFT10_T = 20;

	typedef struct packed {
		logic tx_valid;
		logic [IdW-1:0] tx_id;
		logic [DataW-1:0] tx_data;
		logic [1:0] status;
		logic last_result;
	} res_t;

endpackage

// File: rtl/can_command_responder_heartbeat_unit.sv
// channel   handshake                  payload
// item      item_valid / item_ready    opcode .. valid_flags
// result    result_valid / result_ready tx_valid, tx_id, tx_data, status, last_result
// config    cfg_we (no stall)          cfg_index, cfg_data
//
// an item is registered on transfer and decoded the next cycle into one or two results
// one-result items sustain one per cycle while result_ready is high; an item with
// heartbeat plus ack holds the next item while its results drain one per cycle
// while a finished result waits for result_ready the input register takes one more item,
// then item_ready drops
// arst_n clears the clock, the seconds counter and the last beat time and loads the
// register defaults
module can_command_responder_heartbeat_unit (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input logic opcode,
	input logic [28:0] rx_id,
	input logic [3:0] rx_dlc,
	input logic [7:0] command_byte,
	input logic [7:0] sequence_byte,
	input logic sample_ok,
	input logic signed [22:0] pack_current,
	input logic [19:0] pack_mv,
	input logic [19:0] bus_mv,
	input logic signed [15:0] temp_decideg,
	input logic [2:0] valid_flags,
	output logic result_valid,
	input logic result_ready,
	output logic tx_valid,
	output logic [28:0] tx_id,
	output logic [63:0] tx_data,
	output logic [1:0] status,
	output logic last_result,
	input logic cfg_we,
	input logic [cchb_pkg::CfgIdxW-1:0] cfg_index,
	input logic [cchb_pkg::CfgDataW-1:0] cfg_data
);

	logic [7:0] node_id_q;
	logic [31:0] beat_period_q;
	logic [28:0] cmd_base_q;
	logic [28:0] ack_base_q;
	logic [28:0] beat_base_q;

	logic [31:0] now_q;
	logic [31:0] last_beat_q;
	logic [cchb_pkg::SecW-1:0] sec_q;
	logic [cchb_pkg::RemW-1:0] rem_q;

	logic valid_s1;
	logic opcode_s1;
	logic [28:0] rx_id_s1;
	logic [3:0] rx_dlc_s1;
	logic [7:0] command_byte_s1;
	logic [7:0] sequence_byte_s1;
	logic sample_ok_s1;
	logic signed [22:0] pack_current_s1;
	logic [19:0] pack_mv_s1;
	logic [19:0] bus_mv_s1;
	logic signed [15:0] temp_decideg_s1;
	logic [2:0] valid_flags_s1;

	logic out_valid_q;
	logic out_two_q;
	logic out_idx_q;
	cchb_pkg::res_t res0_q;
	cchb_pkg::res_t res1_q;
	cchb_pkg::res_t res_show;

	logic out_done;
	logic advance;

	logic [28:0] beat_id;
	logic [28:0] ack_id;
	logic [28:0] cmd_id;
	logic [31:0] now_next;
	logic beat_due;
	logic [63:0] beat_data;
	logic [63:0] ack_up;
	cchb_pkg::res_t r0;
	cchb_pkg::res_t r1;
	logic two;
	logic beat_fire;
	logic beat_restart;

	cchb_beat_data u_beat_data (
		.pack_current(pack_current_s1),
		.pack_mv(pack_mv_s1),
		.bus_mv(bus_mv_s1),
		.temp_decideg(temp_decideg_s1),
		.valid_flags(valid_flags_s1),
		.data(beat_data)
	);

	assign out_done = out_valid_q && result_ready && (out_idx_q || !out_two_q);
	assign advance = valid_s1 && (!out_valid_q || out_done);
	assign item_ready = !valid_s1 || advance;

	assign res_show = out_idx_q ? res1_q : res0_q;
	assign result_valid = out_valid_q;
	assign tx_valid = res_show.tx_valid;
	assign tx_id = res_show.tx_id;
	assign tx_data = res_show.tx_data;
	assign status = res_show.status;
	assign last_result = res_show.last_result;

	always_comb begin
		beat_id = beat_base_q + {21'd0, node_id_q};
		ack_id = ack_base_q + {21'd0, node_id_q};
		cmd_id = cmd_base_q + {21'd0, node_id_q};
		now_next = now_q + 32'd1;
		beat_due = (now_next - last_beat_q) >= beat_period_q;
		ack_up = {cchb_pkg::ACK_TAG1, cchb_pkg::ACK_TAG0,
			{(32 - cchb_pkg::SecW){1'b0}}, sec_q, sequence_byte_s1, 8'd0};

		r0 = '{tx_valid: 1'b0, tx_id: '0, tx_data: '0,
			status: cchb_pkg::STATUS_OK, last_result: 1'b1};
		r1 = r0;
		two = 1'b0;
		beat_fire = 1'b0;
		beat_restart = 1'b0;

		priority if (opcode_s1 == cchb_pkg::OP_TICK) begin
			if (beat_due && sample_ok_s1) begin
				beat_fire = 1'b1;
				r0.tx_valid = 1'b1;
				r0.tx_id = beat_id;
				r0.tx_data = beat_data;
			end
		end else if (rx_id_s1 != cmd_id) begin
			r0.status = cchb_pkg::STATUS_OK;
		end else if (rx_dlc_s1 == 4'd0) begin
			r0.status = cchb_pkg::STATUS_BAD_ARG;
		end else begin
			unique case (command_byte_s1)
				cchb_pkg::CMD_PING: begin
					r0.tx_valid = 1'b1;
					r0.tx_id = ack_id;
					r0.tx_data = {ack_up[63:8], cchb_pkg::CMD_PING};
				end
				cchb_pkg::CMD_BEAT: begin
					if (!sample_ok_s1) begin
						r0.status = cchb_pkg::STATUS_SAMPLE_ERR;
					end else begin
						beat_restart = 1'b1;
						two = 1'b1;
						r0.tx_valid = 1'b1;
						r0.tx_id = beat_id;
						r0.tx_data = beat_data;
						r0.last_result = 1'b0;
						r1.tx_valid = 1'b1;
						r1.tx_id = ack_id;
						r1.tx_data = {ack_up[63:8], cchb_pkg::CMD_BEAT};
					end
				end
				default: begin
					r0.tx_valid = 1'b1;
					r0.tx_id = ack_id;
					r0.tx_data = {ack_up[63:8], cchb_pkg::CODE_UNKNOWN};
				end
			endcase
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= '0;
			beat_period_q <= cchb_pkg::BEAT_PERIOD_RST;
			cmd_base_q <= '0;
			ack_base_q <= '0;
			beat_base_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cchb_pkg::REG_NODE_ID: node_id_q <= cfg_data[7:0];
				cchb_pkg::REG_BEAT_PERIOD: beat_period_q <= cfg_data;
				cchb_pkg::REG_CMD_BASE: cmd_base_q <= cfg_data[28:0];
				cchb_pkg::REG_ACK_BASE: ack_base_q <= cfg_data[28:0];
				cchb_pkg::REG_BEAT_BASE: beat_base_q <= cfg_data[28:0];
				default: begin
				end
			endcase
		end
	end

	// millisecond clock, uptime seconds and last beat time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			last_beat_q <= '0;
			sec_q <= '0;
			rem_q <= '0;
		end else if (advance) begin
			if (opcode_s1 == cchb_pkg::OP_TICK) begin
				now_q <= now_next;
				if (now_q == '1) begin
					sec_q <= '0;
					rem_q <= '0;
				end else if (rem_q == cchb_pkg::MS_PER_SEC_LAST) begin
					sec_q <= sec_q + 23'd1;
					rem_q <= '0;
				end else begin
					rem_q <= rem_q + 10'd1;
				end
				if (beat_fire) begin
					last_beat_q <= now_next;
				end
			end else if (beat_restart) begin
				last_beat_q <= now_q;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			opcode_s1 <= opcode;
			rx_id_s1 <= rx_id;
			rx_dlc_s1 <= rx_dlc;
			command_byte_s1 <= command_byte;
			sequence_byte_s1 <= sequence_byte;
			sample_ok_s1 <= sample_ok;
			pack_current_s1 <= pack_current;
			pack_mv_s1 <= pack_mv;
			bus_mv_s1 <= bus_mv;
			temp_decideg_s1 <= temp_decideg;
			valid_flags_s1 <= valid_flags;
		end
	end

	// result register, one or two results per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_two_q <= 1'b0;
			out_idx_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			out_two_q <= two;
			out_idx_q <= 1'b0;
		end else if (out_valid_q && result_ready) begin
			if (out_two_q && !out_idx_q) begin
				out_idx_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res0_q <= r0;
			res1_q <= r1;
		end
	end

endmodule

// File: rtl/cchb_beat_data.sv
module cchb_beat_data (
	input logic signed [22:0] pack_current,
	input logic [19:0] pack_mv,
	input logic [19:0] bus_mv,
	input logic signed [15:0] temp_decideg,
	input logic [2:0] valid_flags,
	output logic [cchb_pkg::DataW-1:0] data
);

	logic [39:0] pack_prod;
	logic [39:0] bus_prod;
	logic cur_neg;
	logic [22:0] cur_mag;
	logic [46:0] cur_prod;
	logic [15:0] cur_q;
	logic [15:0] cur_dA;
	logic temp_neg;
	logic [15:0] temp_mag;
	logic [32:0] temp_prod;
	logic [7:0] temp_q;
	logic [7:0] temp_deg;

	always_comb begin
		pack_prod = {20'd0, pack_mv} * {20'd0, cchb_pkg::RECIP10_V};
		bus_prod = {20'd0, bus_mv} * {20'd0, cchb_pkg::RECIP10_V};

		cur_neg = pack_current[22];
		cur_mag = cur_neg ? (23'd0 - pack_current) : pack_current;
		cur_prod = {24'd0, cur_mag} * {23'd0, cchb_pkg::RECIP100};
		cur_q = cur_prod[cchb_pkg::SHIFT100 +: 16];
		cur_dA = cur_neg ? (16'd0 - cur_q) : cur_q;

		temp_neg = temp_decideg[15];
		temp_mag = temp_neg ? (16'd0 - temp_decideg) : temp_decideg;
		temp_prod = {17'd0, temp_mag} * {16'd0, cchb_pkg::RECIP10_T};
		temp_q = temp_prod[cchb_pkg::SHIFT10_T +: 8];
		temp_deg = temp_neg ? (8'd0 - temp_q) : temp_q;

		data = {5'd0, valid_flags, temp_deg, cur_dA,
			bus_prod[cchb_pkg::SHIFT10_V +: 16], pack_prod[cchb_pkg::SHIFT10_V +: 16]};
	end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;

	typedef struct {
		logic opcode;
		logic [28:0] rx_id;
		logic [3:0] rx_dlc;
		logic [7:0] command_byte;
		logic [7:0] sequence_byte;
		logic sample_ok;
		logic signed [22:0] pack_current;
		logic [19:0] pack_mv;
		logic [19:0] bus_mv;
		logic signed [15:0] temp_decideg;
		logic [2:0] valid_flags;
	} can_rx_item_t;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	logic opcode;
	logic [28:0] rx_id;
	logic [3:0] rx_dlc;
	logic [7:0] command_byte;
	logic [7:0] sequence_byte;
	logic sample_ok;
	logic signed [22:0] pack_current;
	logic [19:0] pack_mv;
	logic [19:0] bus_mv;
	logic signed [15:0] temp_decideg;
	logic [2:0] valid_flags;
	logic result_valid;
	logic result_ready;
	logic tx_valid;
	logic [28:0] tx_id;
	logic [63:0] tx_data;
	logic [1:0] status;
	logic last_result;
	logic cfg_we;
	logic [cchb_pkg::CfgIdxW-1:0] cfg_index;
	logic [cchb_pkg::CfgDataW-1:0] cfg_data;

	// responder state as predicted
	logic [7:0] cfg_node;
	logic [31:0] cfg_beat_period;
	logic [28:0] cfg_cmd_base;
	logic [28:0] cfg_ack_base;
	logic [28:0] cfg_beat_base;
	logic [31:0] uptime_ms = '0;
	logic [31:0] last_beat_ms = '0;

	cchb_pkg::res_t pending_frames[$];
	cchb_pkg::res_t want;
	int fail_count = 0;
	logic idle_en;

	can_command_responder_heartbeat_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.opcode(opcode),
		.rx_id(rx_id),
		.rx_dlc(rx_dlc),
		.command_byte(command_byte),
		.sequence_byte(sequence_byte),
		.sample_ok(sample_ok),
		.pack_current(pack_current),
		.pack_mv(pack_mv),
		.bus_mv(bus_mv),
		.temp_decideg(temp_decideg),
		.valid_flags(valid_flags),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.tx_valid(tx_valid),
		.tx_id(tx_id),
		.tx_data(tx_data),
		.status(status),
		.last_result(last_result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic cchb_pkg::res_t beat_frame(input logic last);
		cchb_pkg::res_t f;
		int cur_da;
		int temp_deg;
		logic [19:0] pack_dv;
		logic [19:0] bus_dv;
		cur_da = int'(pack_current);
		cur_da = cur_da / 100;
		temp_deg = int'(temp_decideg);
		temp_deg = temp_deg / 10;
		pack_dv = 20'(pack_mv / 10);
		bus_dv = 20'(bus_mv / 10);
		f.tx_valid = 1'b1;
		f.tx_id = cfg_beat_base + 29'(cfg_node);
		f.tx_data = {5'b0, valid_flags, temp_deg[7:0], cur_da[15:0], bus_dv[15:0],
			pack_dv[15:0]};
		f.status = cchb_pkg::STATUS_OK;
		f.last_result = last;
		return f;
	endfunction

	function automatic cchb_pkg::res_t ack_frame(input logic [7:0] code);
		cchb_pkg::res_t f;
		logic [31:0] secs;
		secs = uptime_ms / 1000;
		f.tx_valid = 1'b1;
		f.tx_id = cfg_ack_base + 29'(cfg_node);
		f.tx_data = {cchb_pkg::ACK_TAG1, cchb_pkg::ACK_TAG0, secs, sequence_byte, code};
		f.status = cchb_pkg::STATUS_OK;
		f.last_result = 1'b1;
		return f;
	endfunction

	function automatic void predict_responses();
		cchb_pkg::res_t none;
		logic [28:0] cmd_id;
		none = '0;
		none.last_result = 1'b1;
		cmd_id = cfg_cmd_base + 29'(cfg_node);
		if (opcode == cchb_pkg::OP_TICK) begin
			uptime_ms = uptime_ms + 1;
			if (uptime_ms - last_beat_ms >= cfg_beat_period && sample_ok) begin
				pending_frames.push_back(beat_frame(1'b1));
				last_beat_ms = uptime_ms;
			end else begin
				pending_frames.push_back(none);
			end
		end else if (rx_id != cmd_id) begin
			pending_frames.push_back(none);
		end else if (rx_dlc == 4'd0) begin
			none.status = cchb_pkg::STATUS_BAD_ARG;
			pending_frames.push_back(none);
		end else if (command_byte == cchb_pkg::CMD_BEAT) begin
			if (!sample_ok) begin
				none.status = cchb_pkg::STATUS_SAMPLE_ERR;
				pending_frames.push_back(none);
			end else begin
				pending_frames.push_back(beat_frame(1'b0));
				pending_frames.push_back(ack_frame(cchb_pkg::CMD_BEAT));
				last_beat_ms = uptime_ms;
			end
		end else begin
			pending_frames.push_back(ack_frame(command_byte == cchb_pkg::CMD_PING ?
				cchb_pkg::CMD_PING : cchb_pkg::CODE_UNKNOWN));
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready)
				predict_responses();
			if (result_valid && result_ready) begin
				if (pending_frames.size() == 0) begin
					$error("result with nothing pending: tx_id %h tx_data %h", tx_id, tx_data);
					fail_count++;
				end else begin
					want = pending_frames.pop_front();
					if (tx_valid !== want.tx_valid) begin
						$error("tx_valid: expected %b, got %b", want.tx_valid, tx_valid);
						fail_count++;
					end
					if (tx_id !== want.tx_id) begin
						$error("tx_id: expected %h, got %h", want.tx_id, tx_id);
						fail_count++;
					end
					if (tx_data !== want.tx_data) begin
						$error("tx_data: expected %h, got %h", want.tx_data, tx_data);
						fail_count++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fail_count++;
					end
					if (last_result !== want.last_result) begin
						$error("last_result: expected %b, got %b", want.last_result,
							last_result);
						fail_count++;
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		result_ready <= !(idle_en && $urandom_range(99) < 30);
	end

	task automatic send_item(input can_rx_item_t it);
		@(negedge clk);
		while (idle_en && $urandom_range(99) < 30) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		opcode <= it.opcode;
		rx_id <= it.rx_id;
		rx_dlc <= it.rx_dlc;
		command_byte <= it.command_byte;
		sequence_byte <= it.sequence_byte;
		sample_ok <= it.sample_ok;
		pack_current <= it.pack_current;
		pack_mv <= it.pack_mv;
		bus_mv <= it.bus_mv;
		temp_decideg <= it.temp_decideg;
		valid_flags <= it.valid_flags;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
	endtask

	// drop valid and wait for every pending frame plus the pipeline tail
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_frames.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [cchb_pkg::CfgIdxW-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			cchb_pkg::REG_NODE_ID: cfg_node = val[7:0];
			cchb_pkg::REG_BEAT_PERIOD: cfg_beat_period = val;
			cchb_pkg::REG_CMD_BASE: cfg_cmd_base = val[28:0];
			cchb_pkg::REG_ACK_BASE: cfg_ack_base = val[28:0];
			cchb_pkg::REG_BEAT_BASE: cfg_beat_base = val[28:0];
			default: ;
		endcase
	endtask

	function automatic can_rx_item_t random_item();
		can_rx_item_t it;
		it.opcode = cchb_pkg::OP_TICK;
		it.rx_id = 29'($urandom);
		it.rx_dlc = 4'($urandom_range(1, 8));
		it.command_byte = 8'($urandom);
		it.sequence_byte = 8'($urandom);
		it.sample_ok = 1'b1;
		it.pack_current = 23'($urandom);
		it.pack_mv = 20'($urandom);
		it.bus_mv = 20'($urandom);
		it.temp_decideg = 16'($urandom);
		it.valid_flags = 3'($urandom);
		return it;
	endfunction

	function automatic can_rx_item_t tick_item(input logic ok);
		can_rx_item_t it;
		it = random_item();
		it.sample_ok = ok;
		return it;
	endfunction

	function automatic can_rx_item_t frame_item(input logic [7:0] cmd, input logic [3:0] dlc);
		can_rx_item_t it;
		it = random_item();
		it.opcode = cchb_pkg::OP_FRAME;
		it.rx_id = cfg_cmd_base + 29'(cfg_node);
		it.rx_dlc = dlc;
		it.command_byte = cmd;
		return it;
	endfunction

	function automatic can_rx_item_t traffic_item();
		can_rx_item_t it;
		int pick;
		it = random_item();
		it.sample_ok = $urandom_range(99) < 85;
		if ($urandom_range(99) < 45)
			return it;
		it.opcode = cchb_pkg::OP_FRAME;
		pick = $urandom_range(99);
		if (pick < 85)
			it.rx_id = cfg_cmd_base + 29'(cfg_node);
		else if (pick < 92)
			it.rx_id = cfg_cmd_base + 29'(cfg_node) + 29'd1;
		pick = $urandom_range(99);
		if (pick < 7)
			it.rx_dlc = 4'd0;
		else if (pick < 15)
			it.rx_dlc = 4'($urandom_range(9, 15));
		pick = $urandom_range(99);
		if (pick < 40)
			it.command_byte = cchb_pkg::CMD_PING;
		else if (pick < 80)
			it.command_byte = cchb_pkg::CMD_BEAT;
		return it;
	endfunction

	task automatic test_defaults();
		// reset values: node 0, all bases 0, period 1000
		send_item(tick_item(1'b1));
		send_item(tick_item(1'b1));
		send_item(tick_item(1'b0));
		send_item(frame_item(cchb_pkg::CMD_PING, 4'd8));
		send_item(frame_item(cchb_pkg::CMD_BEAT, 4'd2));
		send_item(frame_item(8'h00, 4'd1));
		send_item(frame_item(cchb_pkg::CMD_PING, 4'd0));
		settle();
	endtask

	task automatic test_register_extremes();
		can_rx_item_t it;
		write_reg(cchb_pkg::REG_NODE_ID, 32'd255);
		write_reg(cchb_pkg::REG_CMD_BASE, 32'h1FFF_FFFF);
		write_reg(cchb_pkg::REG_ACK_BASE, 32'h1FFF_FF80);
		write_reg(cchb_pkg::REG_BEAT_BASE, 32'h1FFF_FFFF);
		write_reg(cchb_pkg::REG_BEAT_PERIOD, 32'd0);
		it = tick_item(1'b1);
		it.pack_current = 23'h40_0000;
		it.temp_decideg = 16'h8000;
		it.pack_mv = 20'hF_FFFF;
		it.bus_mv = 20'h0_0000;
		it.valid_flags = 3'd7;
		send_item(it);
		it = tick_item(1'b1);
		it.pack_current = 23'h3F_FFFF;
		it.temp_decideg = 16'h7FFF;
		it.pack_mv = 20'h0_0000;
		it.bus_mv = 20'hF_FFFF;
		it.valid_flags = 3'd0;
		send_item(it);
		// small negatives truncate to zero
		it = tick_item(1'b1);
		it.pack_current = 23'(-99);
		it.temp_decideg = 16'(-9);
		send_item(it);
		send_item(tick_item(1'b0));
		it = frame_item(cchb_pkg::CMD_PING, 4'd8);
		it.rx_id = it.rx_id + 29'd1;
		send_item(it);
		it = frame_item(cchb_pkg::CMD_PING, 4'd1);
		it.sequence_byte = 8'hFF;
		send_item(it);
		it = frame_item(cchb_pkg::CMD_BEAT, 4'd8);
		it.sequence_byte = 8'h00;
		send_item(it);
		it = frame_item(cchb_pkg::CMD_BEAT, 4'd3);
		it.sample_ok = 1'b0;
		send_item(it);
		send_item(frame_item(8'hFF, 4'd8));
		send_item(frame_item(8'h00, 4'd9));
		send_item(frame_item(cchb_pkg::CMD_BEAT, 4'd15));
		it = frame_item(cchb_pkg::CMD_BEAT, 4'd0);
		it.sample_ok = 1'b0;
		send_item(it);
		settle();
		write_reg(cchb_pkg::REG_BEAT_PERIOD, 32'hFFFF_FFFF);
		send_item(tick_item(1'b1));
		send_item(frame_item(cchb_pkg::CMD_BEAT, 4'd4));
		send_item(tick_item(1'b1));
		settle();
	endtask

	task automatic test_tick_run();
		// long tick run with periodic beats and commands mixed in
		write_reg(cchb_pkg::REG_BEAT_PERIOD, 32'd97);
		write_reg(cchb_pkg::REG_NODE_ID, $urandom_range(255));
		for (int i = 0; i < 360; i++) begin
			send_item(tick_item($urandom_range(99) < 85));
			if (i % 60 == 59)
				send_item(frame_item(cchb_pkg::CMD_PING, 4'($urandom_range(1, 8))));
			if (i % 120 == 60)
				send_item(frame_item(cchb_pkg::CMD_BEAT, 4'($urandom_range(1, 8))));
		end
		settle();
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			write_reg(cchb_pkg::REG_NODE_ID, $urandom_range(255));
			case (phase)
				0: write_reg(cchb_pkg::REG_BEAT_PERIOD, 32'd0);
				1: write_reg(cchb_pkg::REG_BEAT_PERIOD, $urandom_range(1, 12));
				2: write_reg(cchb_pkg::REG_BEAT_PERIOD, 32'd1);
				default: write_reg(cchb_pkg::REG_BEAT_PERIOD, 32'hFFFF_FFFF);
			endcase
			write_reg(cchb_pkg::REG_CMD_BASE, 32'(29'($urandom)));
			write_reg(cchb_pkg::REG_ACK_BASE, 32'(29'($urandom)));
			write_reg(cchb_pkg::REG_BEAT_BASE, 32'(29'($urandom)));
			idle_en = (phase != 2);
			for (int n = 0; n < 90; n++) begin
				if (phase == 1 && n == 45)
					settle();
				send_item(traffic_item());
			end
			settle();
		end
		idle_en = 1'b1;
	endtask

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		opcode = cchb_pkg::OP_TICK;
		rx_id = '0;
		rx_dlc = '0;
		command_byte = '0;
		sequence_byte = '0;
		sample_ok = 1'b0;
		pack_current = '0;
		pack_mv = '0;
		bus_mv = '0;
		temp_decideg = '0;
		valid_flags = '0;
		cfg_we = 1'b0;
		cfg_index = cchb_pkg::REG_NODE_ID;
		cfg_data = '0;
		idle_en = 1'b1;
		cfg_node = '0;
		cfg_beat_period = cchb_pkg::BEAT_PERIOD_RST;
		cfg_cmd_base = '0;
		cfg_ack_base = '0;
		cfg_beat_base = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		test_defaults();
		test_register_extremes();
		test_tick_run();
		test_random_traffic();
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
